[design/content_length_deframer_top_assert.svh]
// Assertion macros used by the port checker of the deframer.
`ifndef CONTENT_LENGTH_DEFRAMER_TOP_ASSERT_SVH
`define CONTENT_LENGTH_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CLD_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CLD_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("deframer assertion failed");

`endif

[design/cld_pkg.sv]
// Package with the types, constants and prefix table of the deframer.
package cld_pkg;

   // Header size limit and the widths that follow from it.
   localparam int MAX_HEADER_BYTES = 64;
   localparam int HDR_POS_W = $clog2(MAX_HEADER_BYTES);
   localparam logic [HDR_POS_W-1:0] LAST_HDR_POS = HDR_POS_W'(MAX_HEADER_BYTES - 1);
   localparam logic [HDR_POS_W-1:0] PREFIX_LEN = HDR_POS_W'(16);
   localparam logic [HDR_POS_W-1:0] MIN_HDR_END = HDR_POS_W'(17);

   // Length accumulator saturates at two to the 32nd.
   localparam int ACC_W = 33;
   localparam logic [ACC_W-1:0] ACC_SAT = 33'h1_0000_0000;
   localparam logic [31:0] MAX_BODY_RESET = 32'hFFFF_FFFF;

   // Character codes.
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SEPARATOR,
      PH_BODY,
      PH_STOPPED
   } phase_type;

   typedef enum logic [1:0] {
      NUM_BEFORE,
      NUM_AFTER_PLUS,
      NUM_IN_DIGITS,
      NUM_AFTER_DIGITS
   } number_phase_type;

   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_BAD_PREFIX  = 3'd1,
      ERR_NO_DIGITS   = 3'd2,
      ERR_OVERFLOW    = 3'd3,
      ERR_HEADER_LONG = 3'd4,
      ERR_NEGATIVE    = 3'd5
   } err_code_type;

   // One input word as held by the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } in_word_type;

   // One result word.
   typedef struct packed {
      logic [7:0]   payload_byte;
      logic         payload_valid;
      logic         message_end;
      logic         empty_message;
      logic         error_flag;
      err_code_type error_code;
   } rsp_word_type;

   // Expected header prefix "Content-Length: ", one character per position.
   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = 8'h43;
         4'd1:    ch = 8'h6F;
         4'd2:    ch = 8'h6E;
         4'd3:    ch = 8'h74;
         4'd4:    ch = 8'h65;
         4'd5:    ch = 8'h6E;
         4'd6:    ch = 8'h74;
         4'd7:    ch = 8'h2D;
         4'd8:    ch = 8'h4C;
         4'd9:    ch = 8'h65;
         4'd10:   ch = 8'h6E;
         4'd11:   ch = 8'h67;
         4'd12:   ch = 8'h74;
         4'd13:   ch = 8'h68;
         4'd14:   ch = 8'h3A;
         default: ch = 8'h20;
      endcase
      return ch;
   endfunction

endpackage

[design/cld_input_stage.sv]
// Input register that holds one received word until the core takes it.
module cld_input_stage
   import cld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        advance,
   output in_word_type in_word
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       req_fire;

   // The register frees up in the same cycle the core consumes its word.
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload register needs no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   assign in_word.valid   = in_valid_ff;
   assign in_word.rx_byte = in_byte_ff;

endmodule

[design/cld_frame_core.sv]
// Framing state machine: header parse, separator skip and body count.
module cld_frame_core
   import cld_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [31:0]  csr_write_data,
   input  in_word_type  in_word,
   input  logic         out_free,
   output logic         advance,
   output logic         res_valid,
   output rsp_word_type res_word
);

   phase_type             phase_ff, phase_in;
   number_phase_type      nphase_ff, nphase_in;
   logic                  cr_ff, cr_in;
   logic                  mismatch_ff, mismatch_in;
   logic                  sep_ff, sep_in;
   logic [HDR_POS_W-1:0]  pos_ff, pos_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [31:0]           body_ff, body_in;
   logic [31:0]           max_ff;

   logic [7:0]            c;
   logic                  is_digit, is_blank, hdr_end, body_last, sep_empty;
   logic [ACC_W+3:0]      mac;
   logic [ACC_W-1:0]      acc_num;
   number_phase_type      nph_num;
   err_code_type          num_err, hdr_err;

   assign c = in_word.rx_byte;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_BODY_RESET;
      end else if (csr_write_enable) begin
         max_ff <= csr_write_data;
      end
   end

   // Decode the current word: number step, header errors and body end.
   always_comb begin
      is_digit  = c inside {[8'h30:8'h39]};
      is_blank  = c inside {8'h20, [8'h09:8'h0D]};
      mac       = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {33'b0, c[3:0]};
      nph_num   = nphase_ff;
      acc_num   = acc_ff;
      num_err   = ERR_NONE;
      case (nphase_ff)
         NUM_BEFORE: begin
            if (is_blank) begin
               nph_num = NUM_BEFORE;
            end else if (c == CHAR_PLUS) begin
               nph_num = NUM_AFTER_PLUS;
            end else if (c == CHAR_MINUS) begin
               num_err = ERR_NEGATIVE;
            end else if (!is_digit) begin
               num_err = ERR_NO_DIGITS;
            end else begin
               nph_num = NUM_IN_DIGITS;
            end
         end
         NUM_AFTER_PLUS: begin
            if (!is_digit) begin
               num_err = ERR_NO_DIGITS;
            end else begin
               nph_num = NUM_IN_DIGITS;
            end
         end
         NUM_IN_DIGITS: begin
            if (!is_digit) begin
               nph_num = NUM_AFTER_DIGITS;
            end
         end
         default: begin
            nph_num = NUM_AFTER_DIGITS;
         end
      endcase
      // Accumulate only on a digit that the number part takes in.
      if (is_digit && nphase_ff != NUM_AFTER_DIGITS) begin
         acc_num = (mac > (ACC_W+4)'(ACC_SAT)) ? ACC_SAT : mac[ACC_W-1:0];
      end

      hdr_end = cr_ff && (c == CHAR_LF);
      hdr_err = ERR_NONE;
      if (hdr_end) begin
         if (mismatch_ff || pos_ff < MIN_HDR_END) begin
            hdr_err = ERR_BAD_PREFIX;
         end else if (nphase_ff == NUM_BEFORE || nphase_ff == NUM_AFTER_PLUS) begin
            hdr_err = ERR_NO_DIGITS;
         end else if (acc_ff > {1'b0, max_ff}) begin
            hdr_err = ERR_OVERFLOW;
         end
      end else if (pos_ff >= PREFIX_LEN && !mismatch_ff && num_err != ERR_NONE) begin
         hdr_err = num_err;
      end else if (pos_ff == LAST_HDR_POS) begin
         hdr_err = ERR_HEADER_LONG;
      end

      sep_empty = sep_ff && (acc_ff == '0);
      body_last = ({1'b0, body_ff} + 33'd1) >= acc_ff;
   end

   // Result of the current word.
   always_comb begin
      res_valid = 1'b0;
      res_word  = '{payload_byte: 8'h00, payload_valid: 1'b0, message_end: 1'b0,
                    empty_message: 1'b0, error_flag: 1'b0, error_code: ERR_NONE};
      case (phase_ff)
         PH_HEADER: begin
            res_valid           = (hdr_err != ERR_NONE);
            res_word.error_flag = (hdr_err != ERR_NONE);
            res_word.error_code = hdr_err;
         end
         PH_SEPARATOR: begin
            res_valid              = sep_empty;
            res_word.message_end   = 1'b1;
            res_word.empty_message = 1'b1;
         end
         PH_BODY: begin
            res_valid              = 1'b1;
            res_word.payload_byte  = c;
            res_word.payload_valid = 1'b1;
            res_word.message_end   = body_last;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
      res_valid = res_valid && in_word.valid;
   end

   // A word is consumed when it makes no result or the result register is free.
   assign advance = in_word.valid && (!res_valid || out_free);

   // Next state.
   always_comb begin
      phase_in    = phase_ff;
      nphase_in   = nphase_ff;
      cr_in       = cr_ff;
      mismatch_in = mismatch_ff;
      sep_in      = sep_ff;
      pos_in      = pos_ff;
      acc_in      = acc_ff;
      body_in     = body_ff;
      if (advance) begin
         case (phase_ff)
            PH_HEADER: begin
               if (hdr_err != ERR_NONE) begin
                  phase_in = PH_STOPPED;
               end else if (hdr_end) begin
                  phase_in = PH_SEPARATOR;
                  cr_in    = 1'b0;
                  pos_in   = '0;
                  sep_in   = 1'b0;
                  body_in  = '0;
               end else begin
                  cr_in  = cr_ff ? 1'b0 : (c == CHAR_CR);
                  pos_in = pos_ff + 1'b1;
                  if (pos_ff < PREFIX_LEN) begin
                     if (c != prefix_char(pos_ff[3:0])) begin
                        mismatch_in = 1'b1;
                     end
                  end else if (!mismatch_ff) begin
                     nphase_in = nph_num;
                     acc_in    = acc_num;
                  end
               end
            end
            PH_SEPARATOR: begin
               if (!sep_ff) begin
                  sep_in = 1'b1;
               end else begin
                  sep_in = 1'b0;
                  if (sep_empty) begin
                     phase_in    = PH_HEADER;
                     nphase_in   = NUM_BEFORE;
                     mismatch_in = 1'b0;
                     cr_in       = 1'b0;
                     pos_in      = '0;
                     acc_in      = '0;
                     body_in     = '0;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (body_last) begin
                  phase_in    = PH_HEADER;
                  nphase_in   = NUM_BEFORE;
                  mismatch_in = 1'b0;
                  cr_in       = 1'b0;
                  pos_in      = '0;
                  acc_in      = '0;
                  body_in     = '0;
               end else begin
                  body_in = body_ff + 32'd1;
               end
            end
            default: begin
               phase_in = PH_STOPPED;
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         nphase_ff   <= NUM_BEFORE;
         cr_ff       <= 1'b0;
         mismatch_ff <= 1'b0;
         sep_ff      <= 1'b0;
         pos_ff      <= '0;
         acc_ff      <= '0;
         body_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         nphase_ff   <= nphase_in;
         cr_ff       <= cr_in;
         mismatch_ff <= mismatch_in;
         sep_ff      <= sep_in;
         pos_ff      <= pos_in;
         acc_ff      <= acc_in;
         body_ff     <= body_in;
      end
   end

endmodule

[design/cld_output_stage.sv]
// Result register that holds one result word until the consumer takes it.
module cld_output_stage
   import cld_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         res_load,
   input  rsp_word_type res_word,
   output logic         out_free,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;

   // Free when empty or when the held word leaves in this cycle.
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      if (res_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload register needs no reset.
   always_ff @(posedge clock) begin
      if (res_load) begin
         out_word_ff <= res_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

[design/content_length_deframer_top.sv]
// Top level of the Content-Length deframer.
//
//   channel  direction  handshake              word contents
//   req      in         req_valid/req_ready    req_rx_byte
//   rsp      out        rsp_valid/rsp_ready    payload byte, flags, error code
//   csr      in         csr_write_enable       csr_write_data (max body length)
//
// One received word per cycle is sustained while the result register is
// free. A word accepted by req_ready is held in the input register, and
// its result is loaded from there into the result register, which drives
// rsp_valid. Words that cause no result (header, separator) are consumed
// without waiting for the result register. A stalled result register stalls
// only words that would produce a result. Reset is synchronous and clears all
// control state; after a framing error no result is produced until reset.
module content_length_deframer_top
   import cld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic        rsp_message_end,
   output logic        rsp_empty_message,
   output logic        rsp_error_flag,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   in_word_type  in_word;
   rsp_word_type res_word, rsp_word;
   logic         advance, res_valid, out_free;

   // Input register.
   cld_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .in_word     (in_word)
   );

   // Framing logic.
   cld_frame_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .in_word          (in_word),
      .out_free         (out_free),
      .advance          (advance),
      .res_valid        (res_valid),
      .res_word         (res_word)
   );

   // Result register.
   cld_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .res_load  (advance && res_valid),
      .res_word  (res_word),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   assign rsp_payload_byte  = rsp_word.payload_byte;
   assign rsp_payload_valid = rsp_word.payload_valid;
   assign rsp_message_end   = rsp_word.message_end;
   assign rsp_empty_message = rsp_word.empty_message;
   assign rsp_error_flag    = rsp_word.error_flag;
   assign rsp_error_code    = rsp_word.error_code;

endmodule

[design/cld_port_checker.sv]
// Port-level checker of the deframer and its bind to the top level.
`include "content_length_deframer_top_assert.svh"

module cld_port_checker
   import cld_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_payload_valid,
   input logic       rsp_message_end,
   input logic       rsp_empty_message,
   input logic       rsp_error_flag,
   input logic [2:0] rsp_error_code
);

   logic [14:0] rsp_fields;
   logic        code_ok;
   logic        empty_ok;

   // All result fields as one vector, and the per-word consistency terms.
   assign rsp_fields = {rsp_payload_byte, rsp_payload_valid, rsp_message_end,
                        rsp_empty_message, rsp_error_flag, rsp_error_code};
   assign code_ok    = rsp_error_flag == (rsp_error_code != ERR_NONE);
   assign empty_ok   = rsp_message_end && !rsp_payload_valid && !rsp_error_flag &&
                       (rsp_payload_byte == 8'h00);

   // A stalled result word stays and does not change.
   `CLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fields))

   // The error flag and a nonzero error code always go together.
   `CLD_ASSERT_IMPLY(a_err_code, clock, reset, rsp_valid, code_ok)

   // An empty message ends a message and carries no byte and no error.
   `CLD_ASSERT_IMPLY(a_empty, clock, reset, rsp_valid && rsp_empty_message, empty_ok)

   // Once an error word is delivered, the block falls silent.
   `CLD_ASSERT_NEXT(a_stop, clock, reset, rsp_valid && rsp_ready && rsp_error_flag, !rsp_valid)

endmodule

bind content_length_deframer_top cld_port_checker u_port_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_payload_valid (rsp_payload_valid),
   .rsp_message_end   (rsp_message_end),
   .rsp_empty_message (rsp_empty_message),
   .rsp_error_flag    (rsp_error_flag),
   .rsp_error_code    (rsp_error_code)
);

[bench/testbench.sv]
// Self-checking testbench for the Content-Length deframer with a scoreboard class.
`timescale 1ns / 100ps

module testbench
   import cld_pkg::*;
;

   // Cycles the block may still be busy with words that cause no result.
   localparam int DRAIN_CYCLES = 8;
   // Cycles without any accepted word before the run is declared hung.
   localparam int STALL_LIMIT = 1000;
   // Input words sent per configuration phase of the random part.
   localparam int PHASE_WORDS = 170;

   typedef enum int {
      BROKEN_SHORT,
      BROKEN_PREFIX_MINUS,
      BROKEN_NO_DIGITS,
      BROKEN_OVERFLOW,
      BROKEN_TOO_LONG,
      BROKEN_MINUS,
      BROKEN_BAD_START,
      BROKEN_PLUS_LETTER
   } broken_kind_type;

   // Predicts the result words of the deframer and checks the observed ones.
   class deframer_scoreboard;
      string            prefix_text = "Content-Length: ";
      logic [31:0]      max_length;
      phase_type        phase;
      logic             saw_cr;
      int unsigned      hdr_pos;
      logic             prefix_bad;
      number_phase_type num_phase;
      logic [32:0]      length_acc;
      logic [32:0]      body_count;
      logic             stopped;
      rsp_word_type     expected_q[$];
      int unsigned      errors;

      function new();
         max_length = MAX_BODY_RESET;
         phase = PH_HEADER;
         stopped = 1'b0;
         errors = 0;
         restart_header();
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void restart_header();
         saw_cr = 1'b0;
         hdr_pos = 0;
         prefix_bad = 1'b0;
         num_phase = NUM_BEFORE;
         length_acc = '0;
         body_count = '0;
      endfunction

      function void push_word(logic [7:0] data, logic valid, logic last, logic empty,
                              err_code_type code);
         rsp_word_type w;
         w.payload_byte = data;
         w.payload_valid = valid;
         w.message_end = last;
         w.empty_message = empty;
         w.error_flag = (code != ERR_NONE);
         w.error_code = code;
         expected_q.insert(expected_q.size(), w);
      endfunction

      // A framing error is reported once, then every word is dropped.
      function void raise_error(err_code_type code);
         stopped = 1'b1;
         phase = PH_STOPPED;
         push_word(8'h00, 1'b0, 1'b0, 1'b0, code);
      endfunction

      // Handles one word of the length field; returns an error code or none.
      function err_code_type number_step(logic [7:0] c);
         logic        digit;
         logic [36:0] sum;
         digit = (c >= 8'h30) && (c <= 8'h39);
         case (num_phase)
            NUM_BEFORE: begin
               if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return ERR_NONE;
               if (c == CHAR_PLUS) begin
                  num_phase = NUM_AFTER_PLUS;
                  return ERR_NONE;
               end
               if (c == CHAR_MINUS) return ERR_NEGATIVE;
               if (!digit) return ERR_NO_DIGITS;
            end
            NUM_AFTER_PLUS: begin
               if (!digit) return ERR_NO_DIGITS;
            end
            NUM_IN_DIGITS: begin
               if (!digit) begin
                  num_phase = NUM_AFTER_DIGITS;
                  return ERR_NONE;
               end
            end
            default: return ERR_NONE;
         endcase
         // The accumulator saturates one above the largest register value.
         num_phase = NUM_IN_DIGITS;
         sum = length_acc * 37'd10 + (c - 8'd48);
         length_acc = (sum > ACC_SAT) ? ACC_SAT : sum[32:0];
         return ERR_NONE;
      endfunction

      function void header_step(logic [7:0] c);
         int unsigned  pos;
         err_code_type code;
         pos = hdr_pos;
         // CR LF ends the header; the checks run in a fixed order.
         if (saw_cr && c == CHAR_LF) begin
            if (prefix_bad || pos < 17) raise_error(ERR_BAD_PREFIX);
            else if (num_phase == NUM_BEFORE || num_phase == NUM_AFTER_PLUS)
               raise_error(ERR_NO_DIGITS);
            else if (length_acc > {1'b0, max_length}) raise_error(ERR_OVERFLOW);
            else begin
               phase = PH_SEPARATOR;
               saw_cr = 1'b0;
               hdr_pos = 0;
               body_count = '0;
            end
            return;
         end
         // A word after CR that is not LF clears the CR mark, even if it is a CR itself.
         if (saw_cr) saw_cr = 1'b0;
         else if (c == CHAR_CR) saw_cr = 1'b1;
         if (pos < 16) begin
            if (c != prefix_text[pos]) prefix_bad = 1'b1;
         end else if (!prefix_bad) begin
            code = number_step(c);
            if (code != ERR_NONE) begin
               raise_error(code);
               return;
            end
         end
         if (pos + 1 >= MAX_HEADER_BYTES) begin
            raise_error(ERR_HEADER_LONG);
            return;
         end
         hdr_pos = pos + 1;
      endfunction

      // Notes one accepted input word and queues the result it causes.
      function void note_input(logic [7:0] c);
         if (stopped) return;
         case (phase)
            PH_HEADER: header_step(c);
            PH_SEPARATOR: begin
               if (body_count == 0) body_count = 1;
               else begin
                  body_count = '0;
                  if (length_acc == 0) begin
                     phase = PH_HEADER;
                     restart_header();
                     push_word(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                  end else begin
                     phase = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               body_count = body_count + 1;
               if (body_count >= length_acc) begin
                  phase = PH_HEADER;
                  restart_header();
                  push_word(c, 1'b1, 1'b1, 1'b0, ERR_NONE);
               end else begin
                  push_word(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      // Checks one accepted result word against the oldest expected one.
      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result word: payload_byte %0d, error_code %0d",
                   got.payload_byte, got.error_code);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("payload_valid", want.payload_valid, got.payload_valid);
         compare_field("message_end", want.message_end, got.message_end);
         compare_field("empty_message", want.empty_message, got.empty_message);
         compare_field("error_flag", want.error_flag, got.error_flag);
         compare_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_payload_valid;
   logic        rsp_message_end;
   logic        rsp_empty_message;
   logic        rsp_error_flag;
   logic [2:0]  rsp_error_code;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = 32'h0;

   deframer_scoreboard sb;
   int unsigned        send_idle_pct = 33;
   int unsigned        rsp_idle_pct = 47;
   int unsigned        sent_words = 0;
   int unsigned        quiet_cycles = 0;

   content_length_deframer_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_message_end   (rsp_message_end),
      .rsp_empty_message (rsp_empty_message),
      .rsp_error_flag    (rsp_error_flag),
      .rsp_error_code    (rsp_error_code),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // The receiver stalls at random.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Observes both channels and the register port, and guards against hangs.
   always @(posedge clock) begin : monitor
      rsp_word_type got;
      logic         moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_write_enable) sb.max_length = csr_write_data;
         if (req_valid && req_ready) begin
            sb.note_input(req_rx_byte);
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            got.payload_byte = rsp_payload_byte;
            got.payload_valid = rsp_payload_valid;
            got.message_end = rsp_message_end;
            got.empty_message = rsp_empty_message;
            got.error_flag = rsp_error_flag;
            got.error_code = err_code_type'(rsp_error_code);
            sb.check_result(got);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Sends one input word after a random gap and waits for its handshake.
   task automatic send_byte(input logic [7:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'($urandom_range(0, 255));
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_words++;
   endtask

   task automatic send_text(input string text);
      foreach (text[i]) send_byte(text[i]);
   endtask

   // Holds the sender off until every expected word has come and the block is idle.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Sends one well-formed message with random blanks, sign, padding and filler.
   task automatic send_frame(input int unsigned body_len);
      logic [7:0]  bytes[$];
      string       digits;
      int unsigned room;
      int unsigned pad;
      logic [7:0]  b;
      logic [7:0]  x;
      logic        first;
      for (int i = 0; i < 16; i++) bytes.insert(bytes.size(), sb.prefix_text[i]);
      // Leading blanks; a CR blank is always followed by a space.
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 5))
            0: bytes.insert(bytes.size(), 8'h20);
            1: bytes.insert(bytes.size(), 8'h09);
            2: bytes.insert(bytes.size(), CHAR_LF);
            3: bytes.insert(bytes.size(), 8'h0B);
            4: bytes.insert(bytes.size(), 8'h0C);
            default: begin
               bytes.insert(bytes.size(), CHAR_CR);
               bytes.insert(bytes.size(), 8'h20);
            end
         endcase
      end
      if ($urandom_range(0, 3) == 0) bytes.insert(bytes.size(), CHAR_PLUS);
      repeat ($urandom_range(0, 3)) bytes.insert(bytes.size(), 8'h30);
      digits = $sformatf("%0d", body_len);
      foreach (digits[i]) bytes.insert(bytes.size(), digits[i]);
      // Ignored filler after the digits, sometimes up to the full header size.
      room = MAX_HEADER_BYTES - 2 - bytes.size();
      pad = ($urandom_range(0, 7) == 0) ? room : $urandom_range(0, (room < 6) ? room : 6);
      first = 1'b1;
      while (pad > 0) begin
         b = 8'($urandom_range(0, 255));
         if (b == CHAR_CR && pad >= 2) begin
            x = 8'($urandom_range(0, 255));
            if (x == CHAR_LF) x = 8'h0B;
            bytes.insert(bytes.size(), b);
            bytes.insert(bytes.size(), x);
            pad -= 2;
         end else begin
            if (b == CHAR_CR) b = 8'h20;
            if (first && b >= 8'h30 && b <= 8'h39) b = b ^ 8'h40;
            bytes.insert(bytes.size(), b);
            pad -= 1;
         end
         first = 1'b0;
      end
      bytes.insert(bytes.size(), CHAR_CR);
      bytes.insert(bytes.size(), CHAR_LF);
      // Two unchecked separator words, then the body.
      repeat (2 + body_len) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   // Ends the stream with one malformed header; the block stops after it.
   task automatic send_broken_header();
      broken_kind_type kind;
      kind = broken_kind_type'($urandom_range(0, 7));
      case (kind)
         BROKEN_SHORT: send_text("Content-Length\015\012");
         BROKEN_PREFIX_MINUS: send_text("Content-Lengtx: -5\015\012");
         BROKEN_NO_DIGITS: send_text("Content-Length:  \015\012");
         BROKEN_OVERFLOW: send_text("Content-Length: 42949672960000\015\012");
         BROKEN_TOO_LONG: begin
            send_text("Content-Length: 1");
            repeat (50) send_byte(8'h61);
         end
         BROKEN_MINUS: send_text("Content-Length: -3\015\012");
         BROKEN_BAD_START: send_text("Content-Length: x9\015\012");
         default: send_text("Content-Length: +a\015\012");
      endcase
      // Words after the error are swallowed.
      repeat (12) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      logic [31:0] limit;
      int unsigned cap;
      int unsigned len;
      int unsigned target;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      write_max_length(32'hFFFF_FFFF);

      // Directed: empty body, then blanks of every kind, plus sign, leading
      // zeros, CR CR LF inside the header, CR LF separators and extreme bytes.
      send_text("Content-Length: 0\015\012\015\012");
      send_text("Content-Length: \t\013\014\015 \012+0002 \015\015\012x\015\012\015\012");
      send_byte(8'h00);
      send_byte(8'hFF);

      // Random messages over several limits and three idling patterns.
      for (int p = 0; p < 6; p++) begin
         pause_until_drained();
         case (p / 2)
            0: begin
               send_idle_pct = 33;
               rsp_idle_pct = 47;
            end
            1: begin
               send_idle_pct = 47;
               rsp_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         case (p)
            0: limit = 32'h0;
            1: limit = $urandom_range(1, 40);
            2: limit = 32'hFFFF_FFFF;
            3: limit = 32'd1;
            4: limit = $urandom_range(2, 300);
            default: limit = 32'hFFFF_FFFF;
         endcase
         write_max_length(limit);
         target = sent_words + PHASE_WORDS;
         while (sent_words < target) begin
            cap = (limit < 24) ? limit : 24;
            len = ($urandom_range(0, 3) == 0) ? cap : $urandom_range(0, cap);
            if ($urandom_range(0, 19) == 0) len = (limit < 200) ? limit : 200;
            send_frame(len);
         end
      end

      pause_until_drained();
      send_broken_header();

      // Let the last words settle before the verdict.
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
